>>> hw/rtl/pcmdm_pkg.sv
// Package for the PCM downmix nearest-neighbor resampler.
// Holds the widths, limits, register indexes and state encoding shared by the top level and the verification files.
// No dependencies.
package pcmdm_pkg;

    localparam int DATA_W       = 16;
    localparam int REM_W        = 17;
    localparam int MAX_UPSAMPLE = 8;
    localparam int SHOWN_W      = $clog2(MAX_UPSAMPLE + 1);
    localparam int CNT_W        = $clog2(DATA_W);
    localparam int ADDR_W       = 4;
    localparam int PDATA_W      = 32;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);

    localparam logic [15:0] SOURCE_RATE_RESET = 16'd22050;
    localparam logic [15:0] TARGET_RATE_RESET = 16'd22050;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_UBYTE  = 2'd0;
    localparam logic [1:0] REG_STEREO = 2'd1;
    localparam logic [1:0] REG_SRC    = 2'd2;
    localparam logic [1:0] REG_DST    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_FIX  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

>>> hw/rtl/pcmdm_in_if.sv
// Input channel interface: one source frame per transfer.
// Depends on nothing.
interface pcmdm_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_channel_raw;
    logic [15:0] second_channel_raw;
    logic        end_of_buffer;

    modport source (output valid, first_channel_raw, second_channel_raw, end_of_buffer,
                    input ready);
    modport sink (input valid, first_channel_raw, second_channel_raw, end_of_buffer,
                  output ready);
endinterface

>>> hw/rtl/pcmdm_out_if.sv
// Output channel interface: one mono output sample per transfer.
// Depends on nothing.
interface pcmdm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mono_sample;
    logic               last_of_run;
    logic               ratio_overrange;

    modport source (output valid, mono_sample, last_of_run, ratio_overrange,
                    input ready);
    modport sink (input valid, mono_sample, last_of_run, ratio_overrange,
                  output ready);
endinterface

>>> hw/rtl/pcm_downmix_nearest_resampler.sv
// Top level of the PCM downmix nearest-neighbor resampler.
// Depends on pcmdm_pkg, pcmdm_in_if and pcmdm_out_if.
//
// Usage:
// The in_ch channel takes one source frame per transfer: two raw channel words
// and an end-of-buffer mark. The frame is converted to one signed 16-bit sample
// (unsigned bytes are recentered and scaled, stereo channels are averaged with
// truncation toward zero). The out_ch channel then delivers zero or more copies
// of that sample, as nearest-neighbor resampling from source_rate to
// target_rate requires. The last copy of a frame carries last_of_run, and
// every copy of a frame whose copy count exceeded MAX_UPSAMPLE carries
// ratio_overrange (only MAX_UPSAMPLE copies are delivered then).
// The copy count comes from a division of the remaining phase by the source
// rate, done by one shared 17-bit subtractor: one quotient bit per cycle.
// A frame goes from idle through the division and a fix-up step, then, if it
// has copies, to the emit state, which loads one copy at a time into the output
// register. A frame whose remainder already reaches target_rate skips the
// division. in_ch.ready is high only while the sequencer is idle.
// A stalled receiver holds the output register and the sequencer waits; the
// last copy of a frame may still wait in the output register while the next
// frame is taken in. Reset clears the phase remainder and sets the registers
// to their reset values (rates 22050 Hz, mono, signed 16-bit). The APB port
// has no wait states; the user must write configuration only while the block
// is idle. The block itself does not enforce this.
module pcm_downmix_nearest_resampler (
    input  logic                           clk,
    input  logic                           rst_n,
    pcmdm_in_if.sink                       in_ch,
    pcmdm_out_if.source                    out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcmdm_pkg::ADDR_W-1:0]   paddr,
    input  logic [pcmdm_pkg::PDATA_W-1:0]  pwdata,
    output logic [pcmdm_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import pcmdm_pkg::*;

    // Converts one raw channel word to a signed 16-bit value.
    function automatic logic signed [15:0] chan_value(input logic [15:0] raw,
                                                      input logic is_byte);
        logic signed [15:0] v;
        if (is_byte) begin
            v = {~raw[7], raw[6:0], 8'h00};
        end else begin
            v = raw;
        end
        return v;
    endfunction

    // Configuration registers.
    logic             ubyte_reg;
    logic             stereo_reg;
    logic [15:0]      src_rate_reg;
    logic [15:0]      dst_rate_reg;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    // Sequencer and state.
    state_t           state_reg, state_next;
    logic [REM_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SHOWN_W-1:0] left_reg, left_next;
    logic             capped_reg, capped_next;
    logic             out_valid_reg, out_valid_next;

    // Payload held for the current frame.
    logic signed [15:0] sample_reg;
    logic             eob_reg;
    logic             zero_case_reg;
    logic [15:0]      quo_reg, quo_next;
    logic [15:0]      rem_reg, rem_next;

    // Output register payload.
    logic signed [15:0] out_sample_reg;
    logic             out_last_reg;
    logic             out_flag_reg;

    // Shared subtractor.
    logic [REM_W-1:0] sub_a, sub_b;
    logic [REM_W:0]   sub_diff;
    logic             sub_borrow;

    logic [15:0]      src, dst;
    logic             in_xfer;
    logic             load_out;
    logic             diff_pos;
    logic signed [15:0] ch0_val, ch1_val;
    logic signed [16:0] ch_sum, ch_adj;
    logic signed [15:0] frame_sample;
    logic [REM_W-1:0] copies_full;
    logic             capped_now;
    logic [SHOWN_W-1:0] shown_now;
    logic [16:0]      trial_a;

    // A zero rate counts as one.
    assign src = (src_rate_reg == 16'd0) ? 16'd1 : src_rate_reg;
    assign dst = (dst_rate_reg == 16'd0) ? 16'd1 : dst_rate_reg;

    // ------------------------------------------------------------------
    // APB configuration port. No wait states.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_UBYTE:  prdata = PDATA_W'(ubyte_reg);
            REG_STEREO: prdata = PDATA_W'(stereo_reg);
            REG_SRC:    prdata = PDATA_W'(src_rate_reg);
            REG_DST:    prdata = PDATA_W'(dst_rate_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame conversion, done as the frame is transferred in.
    // ------------------------------------------------------------------
    assign ch0_val = chan_value(in_ch.first_channel_raw, ubyte_reg);
    assign ch1_val = chan_value(in_ch.second_channel_raw, ubyte_reg);
    assign ch_sum  = 17'(ch0_val) + 17'(ch1_val);
    // Adding the sign bit before the shift makes the halving truncate toward zero.
    assign ch_adj  = ch_sum + 17'(ch_sum[16]);
    assign frame_sample = stereo_reg ? ch_adj[16:1] : ch0_val;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // ------------------------------------------------------------------
    // Shared subtractor. In idle it forms dst - remainder; during the
    // division it makes the trial subtraction for one quotient bit; in the
    // fix-up step it forms the new remainder.
    // ------------------------------------------------------------------
    assign trial_a = {rem_reg, quo_reg[15]};

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                sub_a = REM_W'(dst);
                sub_b = phase_reg;
            end
            ST_DIV:
            begin
                sub_a = trial_a;
                sub_b = REM_W'(src);
            end
            ST_FIX:
            begin
                sub_a = zero_case_reg ? phase_reg : REM_W'(src);
                sub_b = zero_case_reg ? REM_W'(dst) : REM_W'(rem_reg);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[REM_W];
    assign diff_pos   = !sub_borrow && (sub_diff[REM_W-1:0] != '0);

    // Copy count for the fix-up step. An ordinary frame rounds the quotient
    // up, a frame at the end of a buffer keeps it truncated.
    assign copies_full = zero_case_reg ? '0 :
                         REM_W'(quo_reg) + REM_W'(!eob_reg && (rem_reg != 16'd0));
    assign capped_now  = copies_full > REM_W'(MAX_UPSAMPLE);
    assign shown_now   = capped_now ? SHOWN_W'(MAX_UPSAMPLE) : copies_full[SHOWN_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        capped_next    = capped_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer) begin
                    // The dividend dst - remainder fits 16 bits when positive.
                    quo_next = sub_diff[15:0];
                    rem_next = '0;
                    cnt_next = '0;
                    state_next = diff_pos ? ST_DIV : ST_FIX;
                end
            end
            ST_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (!sub_borrow) begin
                    rem_next = sub_diff[15:0];
                    quo_next = {quo_reg[14:0], 1'b1};
                end else begin
                    rem_next = trial_a[15:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (eob_reg) begin
                    phase_next = '0;
                end else if (zero_case_reg || (rem_reg != 16'd0)) begin
                    phase_next = sub_diff[REM_W-1:0];
                end else begin
                    phase_next = '0;
                end
                capped_next = capped_now;
                left_next   = shown_now;
                state_next  = (shown_now == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready) begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    left_next      = left_reg - SHOWN_W'(1);
                    if (left_reg == SHOWN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ubyte_reg     <= 1'b0;
            stereo_reg    <= 1'b0;
            src_rate_reg  <= SOURCE_RATE_RESET;
            dst_rate_reg  <= TARGET_RATE_RESET;
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            capped_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_UBYTE:  ubyte_reg    <= pwdata[0];
                    REG_STEREO: stereo_reg   <= pwdata[0];
                    REG_SRC:    src_rate_reg <= pwdata[15:0];
                    REG_DST:    dst_rate_reg <= pwdata[15:0];
                    default:    ;
                endcase
            end
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            capped_reg    <= capped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            sample_reg    <= frame_sample;
            eob_reg       <= in_ch.end_of_buffer;
            zero_case_reg <= !diff_pos;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load_out) begin
            out_sample_reg <= sample_reg;
            out_last_reg   <= (left_reg == SHOWN_W'(1));
            out_flag_reg   <= capped_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.mono_sample     = out_sample_reg;
    assign out_ch.last_of_run     = out_last_reg;
    assign out_ch.ratio_overrange = out_flag_reg;

endmodule

>>> hw/rtl/pcmdm_checker.sv
// Port-level checker for the PCM downmix nearest-neighbor resampler, and its bind.
// Depends on pcm_downmix_nearest_resampler and its channel interfaces.
module pcmdm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_sample,
    input logic        out_last,
    input logic        out_flag
);
    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample)
            && $stable(out_last) && $stable(out_flag))
        else $error("stalled output changed");

    // A frame transfer makes the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a frame transfer");

    // While a run is not finished, no new frame is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input ready in the middle of a run");

    // No result appears in the cycle right after a frame transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("output valid rose right after a frame transfer");
endmodule

bind pcm_downmix_nearest_resampler pcmdm_checker u_pcmdm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.mono_sample),
    .out_last   (out_ch.last_of_run),
    .out_flag   (out_ch.ratio_overrange)
);

>>> verif/pcmdm_copy_checker.sv
`timescale 1ns / 1ps
// Checker for the PCM downmix resampler: watches the frame, sample and register ports.
// It predicts every output sample and compares it. Depends on pcmdm_pkg and the channel interfaces.
module pcmdm_copy_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    pcmdm_in_if                           frame_ch,
    pcmdm_out_if                          sample_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcmdm_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcmdm_pkg::PDATA_W-1:0] pwdata,
    input  logic                          pready,
    output int unsigned                   fail_count,
    output int unsigned                   copies_pending
);
    import pcmdm_pkg::*;

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic signed [DATA_W-1:0] mono_sample;
        logic                     last_of_run;
        logic                     ratio_overrange;
    } copy_t;

    copy_t expected_copies[$];

    logic             cfg_unsigned_byte;
    logic             cfg_stereo;
    logic [15:0]      cfg_source_rate;
    logic [15:0]      cfg_target_rate;
    logic [REM_W-1:0] phase_rem;

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic int channel_level(input logic [15:0] raw);
        if (cfg_unsigned_byte)
        begin
            return (int'(raw[7:0]) - 128) * 256;
        end
        return int'($signed(raw));
    endfunction

    // Works out the copies that one source frame causes and advances the phase.
    task automatic predict_frame(input logic [15:0] first_raw, input logic [15:0] second_raw,
                                 input logic eob);
        int          level;
        int unsigned src;
        int unsigned dst;
        int unsigned rem;
        int unsigned copies;
        int unsigned shown;
        logic        capped;
        copy_t       one;

        if (cfg_stereo)
        begin
            // SystemVerilog integer division truncates toward zero.
            level = (channel_level(first_raw) + channel_level(second_raw)) / 2;
        end
        else
        begin
            level = channel_level(first_raw);
        end

        src = (cfg_source_rate == 16'd0) ? 1 : int'(cfg_source_rate);
        dst = (cfg_target_rate == 16'd0) ? 1 : int'(cfg_target_rate);
        rem = int'(phase_rem);
        copies = 0;

        if (eob)
        begin
            if (dst >= rem)
            begin
                copies = (dst - rem) / src;
            end
            phase_rem = '0;
        end
        else
        begin
            if (dst > rem)
            begin
                copies = (dst - rem + src - 1) / src;
            end
            phase_rem = REM_W'(rem + copies * src - dst);
        end

        capped = (copies > MAX_UPSAMPLE);
        shown  = capped ? MAX_UPSAMPLE : copies;
        for (int unsigned k = 0; k < shown; k++)
        begin
            one.mono_sample     = DATA_W'(level);
            one.last_of_run     = (k + 1 == shown);
            one.ratio_overrange = capped;
            expected_copies.push_back(one);
        end
    endtask

    task automatic check_copy();
        copy_t want;

        if (expected_copies.size() == 0)
        begin
            report_mismatch($sformatf("sample %0d with no sample expected",
                                      sample_ch.mono_sample));
        end
        else
        begin
            want = expected_copies.pop_front();
            if (sample_ch.mono_sample !== want.mono_sample)
            begin
                report_mismatch($sformatf("mono_sample %0d, expected %0d",
                                          sample_ch.mono_sample, want.mono_sample));
            end
            if (sample_ch.last_of_run !== want.last_of_run)
            begin
                report_mismatch($sformatf("last_of_run %b, expected %b",
                                          sample_ch.last_of_run, want.last_of_run));
            end
            if (sample_ch.ratio_overrange !== want.ratio_overrange)
            begin
                report_mismatch($sformatf("ratio_overrange %b, expected %b",
                                          sample_ch.ratio_overrange, want.ratio_overrange));
            end
        end
    endtask

    task automatic apply_write(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        case (addr[3:2])
            REG_UBYTE:  cfg_unsigned_byte = data[0];
            REG_STEREO: cfg_stereo        = data[0];
            REG_SRC:    cfg_source_rate   = data[15:0];
            REG_DST:    cfg_target_rate   = data[15:0];
            default:    ;
        endcase
    endtask

    // Output transfers are checked before a frame at the same edge is predicted:
    // a copy leaving the block always belongs to an earlier frame.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_unsigned_byte = 1'b0;
            cfg_stereo        = 1'b0;
            cfg_source_rate   = SOURCE_RATE_RESET;
            cfg_target_rate   = TARGET_RATE_RESET;
            phase_rem         = '0;
            expected_copies.delete();
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                check_copy();
            end
            if (frame_ch.valid && frame_ch.ready)
            begin
                predict_frame(frame_ch.first_channel_raw, frame_ch.second_channel_raw,
                              frame_ch.end_of_buffer);
            end
            if (psel && penable && pwrite && pready)
            begin
                apply_write(paddr, pwdata);
            end
        end
        copies_pending = expected_copies.size();
    end

endmodule

>>> verif/pcm_downmix_nearest_resampler_tb.sv
`timescale 1ns / 1ps
// Testbench top for pcm_downmix_nearest_resampler: clock, reset, stimulus and verdict.
// Depends on pcmdm_pkg, the channel interfaces, the block and pcmdm_copy_checker.
module pcm_downmix_nearest_resampler_tb;
    import pcmdm_pkg::*;

    // The limit leaves a wide margin over the slowest correct run, even with
    // heavy stalling and the largest copy count.
    localparam int CYCLE_LIMIT      = 400000;
    // A frame that causes no copy still keeps the block busy through its division and fix-up step.
    localparam int SETTLE_CYCLES    = 40;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 54;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } pressure_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int unsigned fail_count;
    int unsigned copies_pending;
    int unsigned cycle_count;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    pcmdm_in_if  frame_ch ();
    pcmdm_out_if sample_ch ();

    pcm_downmix_nearest_resampler u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (frame_ch),
        .out_ch  (sample_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker sees the same ports as the block and keeps its own copy of
    // the registers and of the phase remainder.
    pcmdm_copy_checker u_copy_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_ch       (frame_ch),
        .sample_ch      (sample_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .copies_pending (copies_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost sample ends the run here.
    // The counter starts at zero as a two-state variable.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver decides afresh at every falling edge whether it takes a sample,
    // so stalls land on every phase of the block's copy sequence.
    always @(negedge clk)
    begin
        sample_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic set_pressure(input pressure_t mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
            default:       begin sender_idle_pct = 14; receiver_stall_pct = 14; end
        endcase
    endtask

    // Offers one source frame and returns at the falling edge after its transfer.
    // valid stays high from one frame to the next unless the sender idles.
    task automatic send_frame(input logic [15:0] first_raw, input logic [15:0] second_raw,
                              input logic eob);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(negedge clk);
        end
        frame_ch.valid              <= 1'b1;
        frame_ch.first_channel_raw  <= first_raw;
        frame_ch.second_channel_raw <= second_raw;
        frame_ch.end_of_buffer      <= eob;
        @(posedge clk);
        while (!frame_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Setup phase, access phase, then a quiet phase with psel low so that back-to-back
    // writes never touch psel twice in the same step.
    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every predicted sample has arrived, then lets a frame that
    // causes no copy finish its division before anything else happens.
    task automatic wait_drained();
        frame_ch.valid <= 1'b0;
        while (copies_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Registers are only written with the block idle. The phase remainder is
    // not cleared by a write, so a phase that ended without end of buffer
    // carries its remainder into the new rates.
    task automatic apply_setting(input logic ubyte, input logic stereo,
                                 input logic [15:0] src, input logic [15:0] dst);
        wait_drained();
        write_reg(REG_UBYTE, {15'd0, ubyte});
        write_reg(REG_STEREO, {15'd0, stereo});
        write_reg(REG_SRC, src);
        write_reg(REG_DST, dst);
    endtask

    function automatic int unsigned extreme_rate();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 1;
            default: return 65535;
        endcase
    endfunction

    // Rate pairs: equal rates, modest up- and downsampling, ratios that hit the
    // copy cap, the extreme values (a zero rate counts as one) and plain noise.
    task automatic pick_rates(output logic [15:0] src, output logic [15:0] dst);
        int unsigned s;
        int unsigned d;

        case ($urandom_range(5))
            0:
            begin
                s = $urandom_range(1, 48000);
                d = s;
            end
            1:
            begin
                s = $urandom_range(1000, 48000);
                d = s + $urandom_range(0, 7 * s);
            end
            2:
            begin
                d = $urandom_range(1000, 30000);
                s = d + $urandom_range(0, 3 * d);
            end
            3:
            begin
                s = $urandom_range(1, 2000);
                d = s * $urandom_range(9, 40);
            end
            4:
            begin
                s = extreme_rate();
                d = extreme_rate();
            end
            default:
            begin
                s = $urandom_range(0, 65535);
                d = $urandom_range(0, 65535);
            end
        endcase
        src = (s > 65535) ? 16'hFFFF : 16'(s);
        dst = (d > 65535) ? 16'hFFFF : 16'(d);
    endtask

    initial
    begin
        logic [15:0] src;
        logic [15:0] dst;

        rst_n                        = 1'b0;
        frame_ch.valid               = 1'b0;
        frame_ch.first_channel_raw   = '0;
        frame_ch.second_channel_raw  = '0;
        frame_ch.end_of_buffer       = 1'b0;
        psel                         = 1'b0;
        penable                      = 1'b0;
        pwrite                       = 1'b0;
        paddr                        = '0;
        pwdata                       = '0;
        set_pressure(IDLE_NONE);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: equal rates, mono, signed 16-bit. One copy per frame;
        // sign extremes, and the second channel must be ignored.
        send_frame(16'h0000, 16'hFFFF, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'h7FFF, 16'h1234, 1'b1);

        // Unsigned bytes in stereo with the highest ratio: every frame is capped
        // and flagged, the end-of-buffer frame too. High bytes must be ignored.
        apply_setting(1'b1, 1'b1, 16'd1, 16'hFFFF);
        send_frame(16'h12FF, 16'h3400, 1'b0);
        send_frame(16'hFF00, 16'h00FF, 1'b0);
        send_frame(16'h0080, 16'hAB80, 1'b1);

        // Both rates zero, read as one. Stereo averages that round toward zero.
        apply_setting(1'b0, 1'b1, 16'd0, 16'd0);
        send_frame(16'h8000, 16'h8000, 1'b0);
        send_frame(16'h7FFF, 16'h7FFF, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b0);
        send_frame(16'hFFFD, 16'h0000, 1'b0);
        send_frame(16'h7FFF, 16'h8000, 1'b0);
        send_frame(16'h0001, 16'h0000, 1'b1);

        // Deepest downsampling: only the first frame of the buffer is emitted,
        // and the end-of-buffer frame emits nothing.
        apply_setting(1'b1, 1'b0, 16'hFFFF, 16'd1);
        send_frame(16'hA5FF, 16'h0000, 1'b0);
        send_frame(16'h5A00, 16'h0000, 1'b0);
        send_frame(16'h0001, 16'h0000, 1'b0);
        send_frame(16'hFF7F, 16'h0000, 1'b1);

        // A buffer that starts at 7/3 and changes to 3/7 midway, keeping its
        // remainder; it closes with an end-of-buffer frame that has no copy.
        apply_setting(1'b0, 1'b0, 16'd3, 16'd7);
        send_frame(16'h4000, 16'h0000, 1'b0);
        send_frame(16'hC000, 16'h0000, 1'b0);
        apply_setting(1'b0, 1'b0, 16'd7, 16'd3);
        send_frame(16'h1111, 16'h0000, 1'b0);
        send_frame(16'h2222, 16'h0000, 1'b0);
        send_frame(16'h3333, 16'h0000, 1'b1);

        // Random part: each phase has fresh settings and its own idling pattern.
        // Phases end without forcing end of buffer, so rate changes also hit
        // buffers that are under way.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick_rates(src, dst);
            apply_setting(1'($urandom_range(1)), 1'($urandom_range(1)), src, dst);
            set_pressure(pressure_t'(phase % 4));
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
            begin
                send_frame(16'($urandom), 16'($urandom), ($urandom_range(11) == 0));
            end
        end

        wait_drained();
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
